@@ rtl/core/ppg_pkg.sv @@
`default_nettype none
package ppg_pkg;

	localparam int unsigned PERIOD_BITS_DEF = 24;
	localparam int unsigned COUNT_BITS_DEF  = 16;
	localparam int unsigned BURST_BITS_DEF  = 8;
	localparam int unsigned MIN_PERIOD_DEF  = 250;

	localparam int unsigned PERIOD_RESET = 250000;

	localparam int unsigned CFG_DATA_BITS = 32;
	localparam int unsigned CFG_IDX_BITS  = 3;
	localparam int unsigned AMP_BITS      = 8;
	localparam int unsigned OUT_CNT_BITS  = 16;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_START = 2'd1,
		OP_STOP  = 2'd2,
		OP_SHOT  = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_PERIOD     = 3'd0,
		REG_AMPLITUDE  = 3'd1,
		REG_CONTINUOUS = 3'd2,
		REG_EXT_TRIG   = 3'd3,
		REG_BURST_LEN  = 3'd4
	} cfg_idx_t;

endpackage
`default_nettype wire

@@ rtl/core/programmable_pulse_generator_core.sv @@
`default_nettype none
// Programmable pulse train generator. Each input beat is one tick of the pulse timebase
// carrying a command (tick, start, stop, single shot) and the trigger pin level; each
// input beat yields exactly one result beat with pulse, busy, burst-active, the wrapping
// pulse count and the drive level. An input beat passes an input register, then the
// next-state logic into the result register; the input register holds a beat while
// the result register is full and not taken, and one beat per cycle is sustained as long as
// results are taken.
// Configuration writes are always ready and take effect at once; write them while idle.
module programmable_pulse_generator_core
	import ppg_pkg::*;
#(
	parameter int unsigned PERIOD_BITS = PERIOD_BITS_DEF,
	parameter int unsigned COUNT_BITS  = COUNT_BITS_DEF,
	parameter int unsigned BURST_BITS  = BURST_BITS_DEF,
	parameter int unsigned MIN_PERIOD  = MIN_PERIOD_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [1:0]               opcode,
	input  wire logic                     trigger_in,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic                          pulse_out,
	output logic                          busy_res,
	output logic                          burst_active,
	output logic      [OUT_CNT_BITS-1:0]  pulse_count,
	output logic      [AMP_BITS-1:0]      drive_level,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

	logic [PERIOD_BITS-1:0] period_len;
	logic [AMP_BITS-1:0]    amplitude_level;
	logic                   continuous_mode;
	logic                   ext_trig_en;
	logic [BURST_BITS-1:0]  burst_length;

	logic       valid_s1;
	logic [1:0] opcode_s1;
	logic       trig_s1;
	logic       advance;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid || out_ready);
	assign in_ready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			opcode_s1 <= opcode;
			trig_s1   <= trigger_in;
		end
	end

	ppg_cfg_regs #(
		.PERIOD_BITS(PERIOD_BITS),
		.BURST_BITS (BURST_BITS)
	) u_cfg (
		.clk             (clk),
		.arst_n          (arst_n),
		.wr_en           (cfg_valid && cfg_ready),
		.wr_index        (cfg_index),
		.wr_data         (cfg_data),
		.period_len      (period_len),
		.amplitude_level (amplitude_level),
		.continuous_mode (continuous_mode),
		.ext_trig_en     (ext_trig_en),
		.burst_length    (burst_length)
	);

	ppg_engine #(
		.PERIOD_BITS(PERIOD_BITS),
		.COUNT_BITS (COUNT_BITS),
		.BURST_BITS (BURST_BITS),
		.MIN_PERIOD (MIN_PERIOD)
	) u_engine (
		.clk             (clk),
		.arst_n          (arst_n),
		.take            (advance),
		.opcode          (opcode_s1),
		.trigger_in      (trig_s1),
		.period_len      (period_len),
		.amplitude_level (amplitude_level),
		.continuous_mode (continuous_mode),
		.ext_trig_en     (ext_trig_en),
		.burst_length    (burst_length),
		.out_ready       (out_ready),
		.out_valid       (out_valid),
		.pulse_out       (pulse_out),
		.busy_res        (busy_res),
		.burst_active    (burst_active),
		.pulse_count     (pulse_count),
		.drive_level     (drive_level)
	);

endmodule
`default_nettype wire

@@ rtl/core/ppg_cfg_regs.sv @@
`default_nettype none
module ppg_cfg_regs
	import ppg_pkg::*;
#(
	parameter int unsigned PERIOD_BITS = PERIOD_BITS_DEF,
	parameter int unsigned BURST_BITS  = BURST_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     wr_en,
	input  wire logic [CFG_IDX_BITS-1:0]  wr_index,
	input  wire logic [CFG_DATA_BITS-1:0] wr_data,
	output logic      [PERIOD_BITS-1:0]   period_len,
	output logic      [AMP_BITS-1:0]      amplitude_level,
	output logic                          continuous_mode,
	output logic                          ext_trig_en,
	output logic      [BURST_BITS-1:0]    burst_length
);

	logic [PERIOD_BITS-1:0] period_q;
	logic [AMP_BITS-1:0]    amp_q;
	logic                   cont_q;
	logic                   ext_q;
	logic [BURST_BITS-1:0]  burst_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_BITS'(PERIOD_RESET);
			amp_q    <= '0;
			cont_q   <= 1'b0;
			ext_q    <= 1'b0;
			burst_q  <= '0;
		end else if (wr_en) begin
			case (cfg_idx_t'(wr_index))
				REG_PERIOD:     period_q <= wr_data[PERIOD_BITS-1:0];
				REG_AMPLITUDE:  amp_q    <= wr_data[AMP_BITS-1:0];
				REG_CONTINUOUS: cont_q   <= wr_data[0];
				REG_EXT_TRIG:   ext_q    <= wr_data[0];
				REG_BURST_LEN:  burst_q  <= wr_data[BURST_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign period_len      = period_q;
	assign amplitude_level = amp_q;
	assign continuous_mode = cont_q;
	assign ext_trig_en     = ext_q;
	assign burst_length    = burst_q;

endmodule
`default_nettype wire

@@ rtl/core/ppg_engine.sv @@
`default_nettype none
module ppg_engine
	import ppg_pkg::*;
#(
	parameter int unsigned PERIOD_BITS = PERIOD_BITS_DEF,
	parameter int unsigned COUNT_BITS  = COUNT_BITS_DEF,
	parameter int unsigned BURST_BITS  = BURST_BITS_DEF,
	parameter int unsigned MIN_PERIOD  = MIN_PERIOD_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    take,
	input  wire logic [1:0]              opcode,
	input  wire logic                    trigger_in,
	input  wire logic [PERIOD_BITS-1:0]  period_len,
	input  wire logic [AMP_BITS-1:0]     amplitude_level,
	input  wire logic                    continuous_mode,
	input  wire logic                    ext_trig_en,
	input  wire logic [BURST_BITS-1:0]   burst_length,
	input  wire logic                    out_ready,
	output logic                         out_valid,
	output logic                         pulse_out,
	output logic                         busy_res,
	output logic                         burst_active,
	output logic      [OUT_CNT_BITS-1:0] pulse_count,
	output logic      [AMP_BITS-1:0]     drive_level
);

	localparam int unsigned CMP_BITS = ((PERIOD_BITS > 17) ? PERIOD_BITS : 17) + 1;

	logic                   running_q;
	logic [PERIOD_BITS-1:0] tick_cnt_q;
	logic [BURST_BITS-1:0]  burst_left_q;
	logic                   single_q;
	logic [COUNT_BITS-1:0]  fired_q;
	logic                   trig_prev_q;

	logic                   running_n;
	logic [PERIOD_BITS-1:0] tick_cnt_n;
	logic [BURST_BITS-1:0]  burst_left_n;
	logic                   single_n;
	logic [COUNT_BITS-1:0]  fired_n;
	logic                   fire;
	logic                   started;
	logic                   ev;
	logic                   edge_det;
	logic [CMP_BITS-1:0]    cnt_inc;
	logic                   period_hit;

	logic                    out_valid_q;
	logic                    pulse_q;
	logic                    busy_q;
	logic                    burst_act_q;
	logic [AMP_BITS-1:0]     drive_q;

	assign edge_det   = trigger_in && !trig_prev_q;
	assign cnt_inc    = CMP_BITS'(tick_cnt_q) + CMP_BITS'(1);
	assign period_hit = (cnt_inc >= CMP_BITS'(period_len))
		&& (cnt_inc >= CMP_BITS'(MIN_PERIOD));

	always_comb begin
		running_n    = running_q;
		tick_cnt_n   = tick_cnt_q;
		burst_left_n = burst_left_q;
		single_n     = single_q;
		fire         = 1'b0;
		started      = 1'b0;
		ev           = 1'b0;
		case (op_t'(opcode))
			OP_START: begin
				if (single_q) begin
					fire     = 1'b1;
					single_n = 1'b0;
				end
				running_n    = 1'b1;
				tick_cnt_n   = '0;
				burst_left_n = burst_length;
				started      = 1'b1;
			end
			OP_STOP: begin
				running_n    = 1'b0;
				tick_cnt_n   = '0;
				burst_left_n = '0;
				single_n     = 1'b0;
			end
			default: begin
				if (single_q) begin
					fire     = 1'b1;
					single_n = 1'b0;
				end else if (op_t'(opcode) == OP_SHOT && !running_q) begin
					single_n = 1'b1;
				end
			end
		endcase

		if (running_n && !started) begin
			if (ext_trig_en) begin
				tick_cnt_n = '0;
				ev         = edge_det;
			end else if (period_hit) begin
				tick_cnt_n = '0;
				ev         = 1'b1;
			end else begin
				tick_cnt_n = cnt_inc[PERIOD_BITS-1:0];
			end
			if (ev) begin
				fire = 1'b1;
				if (burst_length != '0) begin
					if (burst_left_q <= BURST_BITS'(1)) begin
						burst_left_n = '0;
						running_n    = 1'b0;
					end else begin
						burst_left_n = burst_left_q - BURST_BITS'(1);
					end
				end else begin
					burst_left_n = '0;
					if (!continuous_mode) begin
						running_n = 1'b0;
					end
				end
				if (!running_n) begin
					tick_cnt_n = '0;
				end
			end
		end

		fired_n = fire ? fired_q + COUNT_BITS'(1) : fired_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q    <= 1'b0;
			tick_cnt_q   <= '0;
			burst_left_q <= '0;
			single_q     <= 1'b0;
			fired_q      <= '0;
			trig_prev_q  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (take) begin
				running_q    <= running_n;
				tick_cnt_q   <= tick_cnt_n;
				burst_left_q <= burst_left_n;
				single_q     <= single_n;
				fired_q      <= fired_n;
				trig_prev_q  <= trigger_in;
				out_valid_q  <= 1'b1;
			end else if (out_ready) begin
				out_valid_q  <= 1'b0;
			end
		end
	end

	// result beat payload
	always_ff @(posedge clk) begin
		if (take) begin
			pulse_q     <= fire;
			busy_q      <= running_n || single_n;
			burst_act_q <= burst_left_n != '0;
			drive_q     <= fire ? amplitude_level : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign pulse_out    = pulse_q;
	assign busy_res     = busy_q;
	assign burst_active = burst_act_q;
	assign pulse_count  = OUT_CNT_BITS'(fired_q);
	assign drive_level  = drive_q;

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
module tb_top;
	import ppg_pkg::*;

	typedef struct packed {
		op_t  op;
		logic trig;
	} tick_item_t;

	typedef struct packed {
		logic                    pulse;
		logic                    busy;
		logic                    burst;
		logic [OUT_CNT_BITS-1:0] count;
		logic [AMP_BITS-1:0]     level;
	} pulse_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic [1:0]               opcode = OP_TICK;
	logic                     trigger_in = 1'b0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic                     pulse_out;
	logic                     busy_res;
	logic                     burst_active;
	logic [OUT_CNT_BITS-1:0]  pulse_count;
	logic [AMP_BITS-1:0]      drive_level;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_BITS-1:0]  cfg_index = REG_PERIOD;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	programmable_pulse_generator_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.trigger_in   (trigger_in),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pulse_out    (pulse_out),
		.busy_res     (busy_res),
		.burst_active (burst_active),
		.pulse_count  (pulse_count),
		.drive_level  (drive_level),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// shadow copy of the registers
	logic [PERIOD_BITS_DEF-1:0] cfg_period = PERIOD_BITS_DEF'(PERIOD_RESET);
	logic [AMP_BITS-1:0]        cfg_amp    = '0;
	logic                       cfg_cont   = 1'b0;
	logic                       cfg_ext    = 1'b0;
	logic [BURST_BITS_DEF-1:0]  cfg_burst  = '0;

	// shadow copy of the generator state
	logic                       running    = 1'b0;
	logic [PERIOD_BITS_DEF-1:0] tick_cnt   = '0;
	logic [BURST_BITS_DEF-1:0]  burst_rem  = '0;
	logic                       shot_armed = 1'b0;
	logic [COUNT_BITS_DEF-1:0]  fired      = '0;
	logic                       trig_q     = 1'b0;

	tick_item_t pending_ticks[$];
	pulse_res_t expected_res[$];
	tick_item_t next_tick;
	pulse_res_t want;
	logic       calm = 1'b0;
	logic       mismatch_seen = 1'b0;
	int         queued = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic pulse_res_t predict_tick(op_t op, logic trig);
		pulse_res_t                 r;
		logic                       fire;
		logic                       started;
		logic                       ev;
		logic                       rise;
		logic [PERIOD_BITS_DEF-1:0] eff;
		fire = 1'b0;
		started = 1'b0;
		ev = 1'b0;
		rise = trig && !trig_q;
		eff = (cfg_period < PERIOD_BITS_DEF'(MIN_PERIOD_DEF)) ?
			PERIOD_BITS_DEF'(MIN_PERIOD_DEF) : cfg_period;
		case (op)
			OP_START: begin
				if (shot_armed) begin
					fire = 1'b1;
					shot_armed = 1'b0;
				end
				running = 1'b1;
				tick_cnt = '0;
				burst_rem = cfg_burst;
				started = 1'b1;
			end
			OP_STOP: begin
				running = 1'b0;
				tick_cnt = '0;
				burst_rem = '0;
				shot_armed = 1'b0;
			end
			default: begin
				if (shot_armed) begin
					fire = 1'b1;
					shot_armed = 1'b0;
				end else if (op == OP_SHOT && !running) begin
					shot_armed = 1'b1;
				end
			end
		endcase
		if (running && !started) begin
			if (cfg_ext) begin
				tick_cnt = '0;
				ev = rise;
			end else if ({1'b0, tick_cnt} + 1 >= {1'b0, eff}) begin
				tick_cnt = '0;
				ev = 1'b1;
			end else begin
				tick_cnt = tick_cnt + 1'b1;
			end
			if (ev) begin
				fire = 1'b1;
				if (cfg_burst != 0) begin
					if (burst_rem <= 1) begin
						burst_rem = '0;
						running = 1'b0;
					end else begin
						burst_rem = burst_rem - 1'b1;
					end
				end else begin
					burst_rem = '0;
					if (!cfg_cont)
						running = 1'b0;
				end
				if (!running)
					tick_cnt = '0;
			end
		end
		trig_q = trig;
		if (fire)
			fired = fired + 1'b1;
		r.pulse = fire;
		r.busy  = running || shot_armed;
		r.burst = burst_rem != 0;
		r.count = OUT_CNT_BITS'(fired);
		r.level = fire ? cfg_amp : '0;
		return r;
	endfunction

	// input beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			opcode <= OP_TICK;
			trigger_in <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				expected_res.push_back(predict_tick(op_t'(opcode), trigger_in));
			if (!in_valid || in_ready) begin
				if (pending_ticks.size() != 0 && (calm || $urandom_range(99) >= 26)) begin
					next_tick = pending_ticks.pop_front();
					in_valid <= 1'b1;
					opcode <= next_tick.op;
					trigger_in <= next_tick.trig;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= calm || $urandom_range(99) >= 26;
			if (out_valid && out_ready) begin
				if (expected_res.size() == 0) begin
					$display("%0t: result beat with nothing expected", $time);
					mismatch_seen = 1'b1;
				end else begin
					want = expected_res.pop_front();
					if (pulse_out !== want.pulse) begin
						$display("%0t: pulse_out expected %0d got %0d", $time, want.pulse,
							pulse_out);
						mismatch_seen = 1'b1;
					end
					if (busy_res !== want.busy) begin
						$display("%0t: busy_res expected %0d got %0d", $time, want.busy,
							busy_res);
						mismatch_seen = 1'b1;
					end
					if (burst_active !== want.burst) begin
						$display("%0t: burst_active expected %0d got %0d", $time, want.burst,
							burst_active);
						mismatch_seen = 1'b1;
					end
					if (pulse_count !== want.count) begin
						$display("%0t: pulse_count expected %0d got %0d", $time, want.count,
							pulse_count);
						mismatch_seen = 1'b1;
					end
					if (drive_level !== want.level) begin
						$display("%0t: drive_level expected %0d got %0d", $time, want.level,
							drive_level);
						mismatch_seen = 1'b1;
					end
				end
			end
		end
	end

	task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_BITS-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_PERIOD:     cfg_period = data[PERIOD_BITS_DEF-1:0];
			REG_AMPLITUDE:  cfg_amp = data[AMP_BITS-1:0];
			REG_CONTINUOUS: cfg_cont = data[0];
			REG_EXT_TRIG:   cfg_ext = data[0];
			REG_BURST_LEN:  cfg_burst = data[BURST_BITS_DEF-1:0];
			default: ;
		endcase
	endtask

	// random bits above the register width
	function automatic logic [CFG_DATA_BITS-1:0] with_junk(logic [CFG_DATA_BITS-1:0] v, int w);
		return (CFG_DATA_BITS'($urandom) << w) | v;
	endfunction

	task automatic configure(logic [PERIOD_BITS_DEF-1:0] period, logic [AMP_BITS-1:0] amp,
		logic cont, logic ext, logic [BURST_BITS_DEF-1:0] burst);
		write_reg(REG_PERIOD, with_junk(CFG_DATA_BITS'(period), PERIOD_BITS_DEF));
		write_reg(REG_AMPLITUDE, with_junk(CFG_DATA_BITS'(amp), AMP_BITS));
		write_reg(REG_CONTINUOUS, with_junk(CFG_DATA_BITS'(cont), 1));
		write_reg(REG_EXT_TRIG, with_junk(CFG_DATA_BITS'(ext), 1));
		write_reg(REG_BURST_LEN, with_junk(CFG_DATA_BITS'(burst), BURST_BITS_DEF));
		if ($urandom_range(2) == 0)
			write_reg(cfg_idx_t'($urandom_range((1 << CFG_IDX_BITS) - 1, int'(REG_BURST_LEN) + 1)),
				$urandom);
	endtask

	task automatic push_tick(op_t op, logic trig);
		tick_item_t it;
		it.op = op;
		it.trig = trig;
		pending_ticks.push_back(it);
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (pending_ticks.size() != 0 || in_valid || expected_res.size() != 0);
	endtask

	// random ticks, mostly opened by a start; quiet runs carry no further start or stop
	task automatic queue_run(int n, logic quiet);
		int   r;
		op_t  op;
		logic lvl;
		lvl = 1'($urandom_range(1));
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(999);
			if (i == 0 && $urandom_range(4) != 0)
				op = OP_START;
			else if (quiet)
				op = (r < 30) ? OP_SHOT : OP_TICK;
			else if (r < 40)
				op = OP_START;
			else if (r < 80)
				op = OP_STOP;
			else if (r < 140)
				op = OP_SHOT;
			else
				op = OP_TICK;
			if (cfg_ext) begin
				if ($urandom_range(99) < 35)
					lvl = ~lvl;
			end else begin
				lvl = 1'($urandom_range(1));
			end
			push_tick(op, lvl);
		end
		queued += n;
	endtask

	initial begin
		logic [PERIOD_BITS_DEF-1:0] period;
		logic [AMP_BITS-1:0]        amp;
		logic [BURST_BITS_DEF-1:0]  burst;
		logic                       ext;
		int                         phase;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// single shot corners at reset settings
		push_tick(OP_TICK, 1'b0);
		push_tick(OP_SHOT, 1'b1);
		push_tick(OP_TICK, 1'b0);
		push_tick(OP_SHOT, 1'b0);
		push_tick(OP_SHOT, 1'b0);
		push_tick(OP_SHOT, 1'b0);
		push_tick(OP_STOP, 1'b0);
		push_tick(OP_SHOT, 1'b0);
		push_tick(OP_START, 1'b1);
		push_tick(OP_SHOT, 1'b0);
		push_tick(OP_START, 1'b0);
		push_tick(OP_STOP, 1'b1);
		wait_drained();

		// trigger edges in burst mode, period below the floor
		configure('0, '1, 1'b1, 1'b1, 8'd2);
		push_tick(OP_START, 1'b1);
		push_tick(OP_TICK, 1'b0);
		push_tick(OP_TICK, 1'b1);
		push_tick(OP_TICK, 1'b1);
		push_tick(OP_TICK, 1'b0);
		push_tick(OP_TICK, 1'b1);
		push_tick(OP_TICK, 1'b0);
		wait_drained();

		// continuous, then burst length raised while running
		configure('1, 8'd1, 1'b1, 1'b1, '0);
		push_tick(OP_START, 1'b1);
		push_tick(OP_TICK, 1'b0);
		push_tick(OP_TICK, 1'b1);
		wait_drained();
		configure(PERIOD_BITS_DEF'(MIN_PERIOD_DEF), 8'd77, 1'b1, 1'b1, 8'd2);
		push_tick(OP_TICK, 1'b0);
		push_tick(OP_TICK, 1'b1);
		wait_drained();

		phase = 0;
		while (queued < 2000) begin
			ext = 1'($urandom_range(1));
			case ($urandom_range(7))
				0: period = '0;
				1: period = PERIOD_BITS_DEF'(1);
				2: period = PERIOD_BITS_DEF'(MIN_PERIOD_DEF - 1);
				3: period = PERIOD_BITS_DEF'(MIN_PERIOD_DEF);
				4: period = PERIOD_BITS_DEF'(MIN_PERIOD_DEF + 1);
				5: period = ($urandom_range(5) == 0) ? '1 : PERIOD_BITS_DEF'($urandom);
				default: period = PERIOD_BITS_DEF'($urandom_range(MIN_PERIOD_DEF + 30,
					MIN_PERIOD_DEF));
			endcase
			case ($urandom_range(3))
				0: amp = '0;
				1: amp = '1;
				default: amp = AMP_BITS'($urandom);
			endcase
			case ($urandom_range(5))
				0: burst = '1;
				1: burst = BURST_BITS_DEF'(1);
				2: burst = BURST_BITS_DEF'(2);
				default: burst = BURST_BITS_DEF'($urandom_range(5));
			endcase
			configure(period, amp, 1'($urandom_range(1)), ext, burst);
			calm = (phase == 2);
			if (ext)
				queue_run($urandom_range(250, 150), 1'b0);
			else
				queue_run($urandom_range(560, 260), $urandom_range(2) != 0);
			wait_drained();
			calm = 1'b0;
			phase++;
		end

		repeat (8) @(posedge clk);
		if (!mismatch_seen && expected_res.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
